### rtl/core/ttl_pkg.sv
`timescale 1ns / 1ps
package ttl_pkg;
    localparam int TableEntriesDef = 17;
    localparam int TempMinDef      = -40;
    localparam int TempStepDef     = 10;
    localparam int RwW = 18;
    localparam logic [23:0] ResMax = 24'hFFFFFF;

    localparam logic [0:0] RegFixedRes  = 1'b0;
    localparam logic [0:0] RegFullScale = 1'b1;

    localparam logic [1:0] StInTable = 2'd0;
    localparam logic [1:0] StCold    = 2'd1;
    localparam logic [1:0] StHot     = 2'd2;

    typedef enum logic [2:0] {
        t_idle, t_mul, t_div1, t_search, t_div2, t_out
    } t_state;

    function automatic logic [RwW-1:0] table_entry(input int idx);
        logic [RwW-1:0] v;
        begin
            case (idx)
                0: v = 18'd218997;  1: v = 18'd123029;  2: v = 18'd72148;
                3: v = 18'd43950;   4: v = 18'd27695;   5: v = 18'd17988;
                6: v = 18'd12006;   7: v = 18'd8180;    8: v = 18'd5679;
                9: v = 18'd4024;    10: v = 18'd2905;   11: v = 18'd2133;
                12: v = 18'd1591;   13: v = 18'd1204;   14: v = 18'd923;
                15: v = 18'd716;    16: v = 18'd562;
                default: v = 18'd562;
            endcase
            return v;
        end
    endfunction
endpackage

### rtl/core/ttl_if.sv
`timescale 1ns / 1ps
interface ttl_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_sample;
    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface ttl_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] temperature;
    logic [23:0]        resistance;
    logic [1:0]         range_status;
    modport source (output valid, output temperature, output resistance,
                    output range_status, input ready);
    modport sink (input valid, input temperature, input resistance,
                  input range_status, output ready);
endinterface

interface ttl_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [19:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/thermistor_table_linearizer_top.sv
`timescale 1ns / 1ps
// The path from an accepted request to a valid result runs through the bit-serial
// multiply, the resistance division, the search (one entry a cycle) and the
// interpolation division. Out-of-table results skip the interpolation; a zero sample
// or one at or above full scale skips the multiply and both divisions.
// One request at a time: the next is taken once the block is back in idle after the result is accepted.
// Synchronous active-low reset restores the register defaults and empties the block.
module thermistor_table_linearizer_top #(
    parameter int TEMP_MIN      = ttl_pkg::TempMinDef,
    parameter int TEMP_STEP     = ttl_pkg::TempStepDef
) (
    input logic i_clk,
    input logic i_rst_n,
    ttl_cfg_if.sink i_cfg,
    ttl_in_if.sink  i_in,
    ttl_out_if.source o_out
);
    import ttl_pkg::*;

    // The calibration table is fixed, so its length is too.
    localparam int TABLE_ENTRIES = TableEntriesDef;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int NW = 36;
    // Widest bracket times the largest step times 32, plus the bracket, fits in 28 bits.
    localparam int FW = 28;

    t_state r_state, n_state;
    logic [19:0] r_fr;
    logic [15:0] r_fs;
    logic [11:0] r_smp;
    logic [NW-1:0] r_acc;      // product, then dividend shifted out into the remainder
    logic [NW-1:0] r_quo;
    logic [12:0]   r_rem;
    logic [5:0]  r_cnt;
    logic [23:0] r_res;
    logic [IW-1:0] r_idx;
    logic [FW-1:0] r_num;
    logic [FW-1:0] r_q2;
    logic [19:0] r_rem2;
    logic [18:0] r_den;
    logic signed [11:0] r_temp;
    logic [1:0]  r_st;

    logic [RwW-1:0] w_hi, w_lo, w_first, w_last;
    assign w_hi    = table_entry(int'(r_idx));
    assign w_lo    = table_entry(int'(r_idx) + 1);
    assign w_first = table_entry(0);
    assign w_last  = table_entry(TABLE_ENTRIES - 1);

    function automatic logic signed [11:0] et16(input int i);
        return 12'((TEMP_MIN + i * TEMP_STEP) * 16);
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == t_idle);
    assign o_out.valid = (r_state == t_out);
    assign o_out.temperature  = r_temp;
    assign o_out.resistance   = r_res;
    assign o_out.range_status = r_st;

    logic [13:0] w_trial;
    logic [20:0] w_trial2;
    assign w_trial  = {r_rem, r_acc[NW-1]} - {2'b0, r_smp};
    assign w_trial2 = {r_rem2, r_num[FW-1]} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle;
            r_fr <= 20'd10000;
            r_fs <= 16'd4095;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    RegFixedRes:  r_fr <= i_cfg.data;
                    RegFullScale: r_fs <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle:   if (i_in.valid) n_state = t_mul;
            t_mul:    if (r_smp == 12'd0 || {4'd0, r_smp} >= r_fs) n_state = t_search;
                      else if (r_cnt == 6'd15) n_state = t_div1;
            t_div1:   if (r_cnt == 6'(NW - 1)) n_state = t_search;
            t_search: if (r_st != StInTable || r_res > {6'd0, w_first} ||
                          r_res < {6'd0, w_last})
                          n_state = t_out;
                      else if ({6'd0, w_lo} <= r_res || int'(r_idx) >= TABLE_ENTRIES - 2)
                          n_state = t_div2;
            t_div2:   if (r_cnt == 6'(FW)) n_state = t_out;
            t_out:    if (o_out.ready) n_state = t_idle;
            default:  n_state = t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            t_idle: begin
                r_smp <= i_in.adc_sample;
                r_acc <= '0;
                r_quo <= {20'd0, r_fs - {4'd0, i_in.adc_sample}};
                r_cnt <= '0;
                r_st  <= StInTable;
                r_idx <= '0;
            end
            t_mul: begin
                // shift-add multiply, one bit of (full scale - sample) per cycle
                if (r_smp == 12'd0) begin
                    r_res <= ResMax; r_st <= StCold; r_temp <= et16(0);
                end else if ({4'd0, r_smp} >= r_fs) begin
                    r_res <= '0; r_st <= StHot; r_temp <= et16(TABLE_ENTRIES - 1);
                end else begin
                    r_acc <= (r_acc << 1) + (r_quo[15] ? {16'd0, r_fr} : '0);
                    r_quo <= r_quo << 1;
                    r_cnt <= (r_cnt == 6'd15) ? 6'd0 : r_cnt + 6'd1;
                    r_rem <= '0;
                end
            end
            t_div1: begin
                if (!w_trial[13]) begin
                    r_rem <= w_trial[12:0];
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[11:0], r_acc[NW-1]};
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_acc <= r_acc << 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(NW - 1)) begin
                    if (r_quo[NW-2:23] != '0 ||
                        (r_quo[22:0] == 23'h7FFFFF && !w_trial[13]))
                        r_res <= ResMax;
                    else
                        r_res <= {r_quo[22:0], ~w_trial[13]};
                end
            end
            t_search: begin
                r_cnt <= '0;
                if (r_res > {6'd0, w_first}) begin
                    r_st <= StCold; r_temp <= et16(0);
                end else if (r_res < {6'd0, w_last}) begin
                    r_st <= StHot; r_temp <= et16(TABLE_ENTRIES - 1);
                end else if ({6'd0, w_lo} <= r_res || int'(r_idx) >= TABLE_ENTRIES - 2) begin
                    r_temp <= et16(int'(r_idx));
                    // numerator is (hi - R)*step*16, doubled, plus hi - lo for rounding; denominator doubled
                    r_num  <= FW'((({6'd0, w_hi} - r_res) * TEMP_STEP * 32) +
                                  ({6'd0, w_hi} - {6'd0, w_lo}));
                    r_den  <= {w_hi - w_lo, 1'b0};
                    r_rem2 <= '0;
                    r_q2   <= '0;
                    if (w_hi <= w_lo) r_cnt <= 6'(FW);
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            t_div2: begin
                if (r_cnt == 6'(FW)) begin
                    r_temp <= r_temp + 12'(r_q2);
                end else begin
                    if (!w_trial2[20]) begin
                        r_rem2 <= w_trial2[19:0];
                        r_q2   <= {r_q2[FW-2:0], 1'b1};
                    end else begin
                        r_rem2 <= {r_rem2[18:0], r_num[FW-1]};
                        r_q2   <= {r_q2[FW-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            default: ;
        endcase
    end
endmodule
